FILE: rtl/disk_inflated_obstacle_grid_macros.svh
// Assertion macros used by the obstacle grid back end (dig_back).
// Each macro expects clock aclk and active-low reset aresetn in the using module.
`ifndef DISK_INFLATED_OBSTACLE_GRID_MACROS_SVH
`define DISK_INFLATED_OBSTACLE_GRID_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DIG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DIG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/dig_pkg.sv
// Package for the disk-inflated obstacle grid: sizes, codes, command types
// and the disk row mask function. Depends on nothing.
`default_nettype none

package dig_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_RADIUS = 7;

    localparam int OP_W    = 2;
    localparam int COORD_W = 8;
    localparam int OCC_W   = 8;
    localparam int DIM_W   = 9;
    localparam int LIM_W   = 6;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 4;
    localparam int REG_IDX_W = 2;

    localparam int ROW_AW  = $clog2(MAX_HEIGHT);
    localparam int TY_W    = DIM_W + 1;
    localparam int DISK_N  = 2 * MAX_RADIUS + 1;
    localparam int ROWK_W  = $clog2(DISK_N);
    localparam int SUM_W   = $clog2(2 * MAX_RADIUS * MAX_RADIUS + 1);
    localparam int LIMS_W  = (LIM_W > SUM_W) ? LIM_W : SUM_W;
    localparam int WIDE_W  = MAX_WIDTH + MAX_RADIUS;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DISK_LIMIT = 2'd2;

    localparam logic [DIM_W-1:0] MAP_WIDTH_RESET  = DIM_W'(256);
    localparam logic [DIM_W-1:0] MAP_HEIGHT_RESET = DIM_W'(256);
    localparam logic [LIM_W-1:0] DISK_LIMIT_RESET = LIM_W'(9);

    localparam logic signed [OCC_W-1:0] OCC_THRESHOLD = OCC_W'(50);

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_LOAD,
        CMD_QUERY,
        CMD_OFFMAP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
    } cmd_t;

    typedef struct packed {
        logic [DIM_W-1:0]  eff_w;
        logic [DIM_W-1:0]  eff_h;
        logic [LIMS_W-1:0] lim;
    } geom_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_LOAD,
        B_DRAIN,
        B_QUERY
    } back_state_t;

    // Bit j is set when column offset j-MAX_RADIUS lies inside the disk on row k.
    function automatic logic [DISK_N-1:0] disk_row_mask(input logic [ROWK_W-1:0] k,
                                                        input logic [LIMS_W-1:0] lim);
        logic [DISK_N-1:0] m;
        int dy;
        int dx;
        int s;
        dy = int'(k) - MAX_RADIUS;
        for (int j = 0; j < DISK_N; j++) begin
            dx = j - MAX_RADIUS;
            s = dx * dx + dy * dy;
            m[j] = (s <= int'(lim));
        end
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/disk_inflated_obstacle_grid.sv
// A query result passes through the queue entry, the row read register and the output register;
// a query off the map skips the row read. A result waits while the output is stalled by m_ready low.
// In the back end a clear resets the per-row valid bits, a query reads one row, and an obstacle
// load takes one disk row per cycle through the row memory's read-modify-write port, plus drain.
// A two-entry queue takes items while the back end works; s_ready falls only when it is full.
// Reset: map size 256 x 256, disk limit 9; per-row valid bits clear the grid at once.
`default_nettype none

module disk_inflated_obstacle_grid (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [dig_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [dig_pkg::DATA_W-1:0]        pwdata,
    output logic [dig_pkg::DATA_W-1:0]             prdata,
    output logic                                   pready,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [dig_pkg::OP_W-1:0]          s_operation,
    input  wire logic [dig_pkg::COORD_W-1:0]       s_cell_x,
    input  wire logic [dig_pkg::COORD_W-1:0]       s_cell_y,
    input  wire logic signed [dig_pkg::OCC_W-1:0]  s_occupancy,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_blocked
);

    logic [dig_pkg::DIM_W-1:0] map_width_reg, map_width_next;
    logic [dig_pkg::DIM_W-1:0] map_height_reg, map_height_next;
    logic [dig_pkg::LIM_W-1:0] disk_limit_reg, disk_limit_next;
    logic [dig_pkg::REG_IDX_W-1:0] reg_idx;
    logic          cfg_write;
    dig_pkg::geom_t geom;
    logic          q_full;
    logic          q_push;
    dig_pkg::cmd_t q_push_cmd;
    logic          q_pop;
    logic          q_head_valid;
    dig_pkg::cmd_t q_head_cmd;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[dig_pkg::ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        map_width_next  = map_width_reg;
        map_height_next = map_height_reg;
        disk_limit_next = disk_limit_reg;
        prdata          = '0;
        case (reg_idx)
            dig_pkg::REG_MAP_WIDTH: begin
                prdata = dig_pkg::DATA_W'(map_width_reg);
                if (cfg_write) begin
                    map_width_next = pwdata[dig_pkg::DIM_W-1:0];
                end
            end
            dig_pkg::REG_MAP_HEIGHT: begin
                prdata = dig_pkg::DATA_W'(map_height_reg);
                if (cfg_write) begin
                    map_height_next = pwdata[dig_pkg::DIM_W-1:0];
                end
            end
            dig_pkg::REG_DISK_LIMIT: begin
                prdata = dig_pkg::DATA_W'(disk_limit_reg);
                if (cfg_write) begin
                    disk_limit_next = pwdata[dig_pkg::LIM_W-1:0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg  <= dig_pkg::MAP_WIDTH_RESET;
            map_height_reg <= dig_pkg::MAP_HEIGHT_RESET;
            disk_limit_reg <= dig_pkg::DISK_LIMIT_RESET;
        end else begin
            map_width_reg  <= map_width_next;
            map_height_reg <= map_height_next;
            disk_limit_reg <= disk_limit_next;
        end
    end

    // Sizes beyond the store act as the store size; the disk limit saturates.
    always_comb begin
        geom.eff_w = (map_width_reg > dig_pkg::DIM_W'(dig_pkg::MAX_WIDTH)) ?
                     dig_pkg::DIM_W'(dig_pkg::MAX_WIDTH) : map_width_reg;
        geom.eff_h = (map_height_reg > dig_pkg::DIM_W'(dig_pkg::MAX_HEIGHT)) ?
                     dig_pkg::DIM_W'(dig_pkg::MAX_HEIGHT) : map_height_reg;
        geom.lim   = (dig_pkg::LIMS_W'(disk_limit_reg) >
                      dig_pkg::LIMS_W'(dig_pkg::MAX_RADIUS * dig_pkg::MAX_RADIUS)) ?
                     dig_pkg::LIMS_W'(dig_pkg::MAX_RADIUS * dig_pkg::MAX_RADIUS) :
                     dig_pkg::LIMS_W'(disk_limit_reg);
    end

    dig_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_cell_x    (s_cell_x),
        .s_cell_y    (s_cell_y),
        .s_occupancy (s_occupancy),
        .geom        (geom),
        .q_full      (q_full),
        .push        (q_push),
        .cmd         (q_push_cmd)
    );

    dig_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    dig_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .geom      (geom),
        .cmd_valid (q_head_valid),
        .cmd_head  (q_head_cmd),
        .cmd_pop   (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_blocked (m_blocked)
    );

endmodule

`default_nettype wire

FILE: rtl/dig_front.sv
// Front end of the obstacle grid: accepts items and turns them into commands.
// Uses dig_pkg; feeds dig_queue.
`default_nettype none

module dig_front (
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [dig_pkg::OP_W-1:0]      s_operation,
    input  wire logic [dig_pkg::COORD_W-1:0]   s_cell_x,
    input  wire logic [dig_pkg::COORD_W-1:0]   s_cell_y,
    input  wire logic signed [dig_pkg::OCC_W-1:0] s_occupancy,
    input  wire dig_pkg::geom_t                geom,
    input  wire logic                          q_full,
    output logic                               push,
    output dig_pkg::cmd_t                      cmd
);

    logic on_map;
    logic is_obstacle;
    logic accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    assign on_map = (dig_pkg::DIM_W'(s_cell_x) < geom.eff_w) &&
                    (dig_pkg::DIM_W'(s_cell_y) < geom.eff_h);
    assign is_obstacle = (s_occupancy < 0) || (s_occupancy >= dig_pkg::OCC_THRESHOLD);

    // Loads of free cells or off-map centers, and unused codes, are taken and dropped.
    always_comb begin
        push     = 1'b0;
        cmd.kind = dig_pkg::CMD_CLEAR;
        cmd.x    = s_cell_x;
        cmd.y    = s_cell_y;
        case (s_operation)
            dig_pkg::OP_CLEAR: begin
                push     = accept;
                cmd.kind = dig_pkg::CMD_CLEAR;
            end
            dig_pkg::OP_LOAD: begin
                push     = accept && is_obstacle && on_map;
                cmd.kind = dig_pkg::CMD_LOAD;
            end
            dig_pkg::OP_QUERY: begin
                push     = accept;
                cmd.kind = on_map ? dig_pkg::CMD_QUERY : dig_pkg::CMD_OFFMAP;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/dig_queue.sv
// Two-entry command queue between the front and back ends of the obstacle grid.
// Uses dig_pkg for the command type.
`default_nettype none

module dig_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire dig_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output dig_pkg::cmd_t      head_cmd
);

    dig_pkg::cmd_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dig_back.sv
// Back end of the obstacle grid: row-wide grid memory, disk stamping and queries.
// Uses dig_pkg and the assertion macros; takes commands from dig_queue.
`default_nettype none
`include "disk_inflated_obstacle_grid_macros.svh"

module dig_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire dig_pkg::geom_t geom,
    input  wire logic          cmd_valid,
    input  wire dig_pkg::cmd_t cmd_head,
    output logic               cmd_pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic               m_blocked
);

    dig_pkg::back_state_t state_reg, state_next;

    logic [dig_pkg::MAX_WIDTH-1:0] grid_mem [dig_pkg::MAX_HEIGHT];
    logic [dig_pkg::MAX_HEIGHT-1:0] row_valid_reg;

    dig_pkg::cmd_t                  cmd_reg, cmd_next;
    logic [dig_pkg::ROWK_W-1:0]     row_k_reg, row_k_next;
    logic                           wr_pend_reg, wr_pend_next;
    logic [dig_pkg::ROW_AW-1:0]     wr_addr_reg, wr_addr_next;
    logic [dig_pkg::MAX_WIDTH-1:0]  mask_reg, mask_next;
    logic [dig_pkg::MAX_WIDTH-1:0]  rd_data_reg;
    logic                           rd_row_valid_reg;
    logic                           out_valid_reg, out_valid_next;
    logic                           out_bit_reg, out_bit_next;

    logic                           rd_en;
    logic [dig_pkg::ROW_AW-1:0]     rd_addr;
    logic                           clear_grid;
    logic                           out_free;
    logic                           out_load;
    logic                           out_bit;
    logic [dig_pkg::TY_W-1:0]       ty;
    logic                           ty_ok;
    logic [dig_pkg::DISK_N-1:0]     disk_mask;
    logic [dig_pkg::WIDE_W-1:0]     wide_mask;
    logic [dig_pkg::MAX_WIDTH-1:0]  col_mask;
    logic [dig_pkg::MAX_WIDTH-1:0]  wr_data;

    assign out_free  = !out_valid_reg || m_ready;
    assign m_valid   = out_valid_reg;
    assign m_blocked = out_bit_reg;

    // Row of the disk handled this cycle; negative rows wrap and set the top bit.
    assign ty = dig_pkg::TY_W'(cmd_reg.y) + dig_pkg::TY_W'(row_k_reg)
              - dig_pkg::TY_W'(dig_pkg::MAX_RADIUS);
    assign ty_ok = !ty[dig_pkg::TY_W-1] && (ty[dig_pkg::DIM_W-1:0] < geom.eff_h);

    // The disk row is placed so that offset zero lands on the center column.
    assign disk_mask = dig_pkg::disk_row_mask(row_k_reg, geom.lim);
    assign wide_mask = dig_pkg::WIDE_W'(disk_mask) << cmd_reg.x;
    assign col_mask  = ~({dig_pkg::MAX_WIDTH{1'b1}} << geom.eff_w);

    // A row never written since the last clear reads as all free.
    assign wr_data = (rd_row_valid_reg ? rd_data_reg : '0) | mask_reg;

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        row_k_next     = row_k_reg;
        wr_pend_next   = 1'b0;
        wr_addr_next   = wr_addr_reg;
        mask_next      = mask_reg;
        cmd_pop        = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = cmd_head.y;
        clear_grid     = 1'b0;
        out_load       = 1'b0;
        out_bit        = 1'b1;
        case (state_reg)
            dig_pkg::B_IDLE: begin
                if (cmd_valid) begin
                    case (cmd_head.kind)
                        dig_pkg::CMD_CLEAR: begin
                            cmd_pop    = 1'b1;
                            clear_grid = 1'b1;
                        end
                        dig_pkg::CMD_LOAD: begin
                            cmd_pop    = 1'b1;
                            cmd_next   = cmd_head;
                            row_k_next = '0;
                            state_next = dig_pkg::B_LOAD;
                        end
                        dig_pkg::CMD_QUERY: begin
                            cmd_pop    = 1'b1;
                            cmd_next   = cmd_head;
                            rd_en      = 1'b1;
                            rd_addr    = cmd_head.y;
                            state_next = dig_pkg::B_QUERY;
                        end
                        dig_pkg::CMD_OFFMAP: begin
                            if (out_free) begin
                                cmd_pop  = 1'b1;
                                out_load = 1'b1;
                                out_bit  = 1'b1;
                            end
                        end
                        default: begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            dig_pkg::B_LOAD: begin
                // Read this row while the previous row's merged word is written back.
                rd_en        = ty_ok;
                rd_addr      = ty[dig_pkg::ROW_AW-1:0];
                wr_pend_next = ty_ok;
                wr_addr_next = ty[dig_pkg::ROW_AW-1:0];
                mask_next    = wide_mask[dig_pkg::WIDE_W-1:dig_pkg::MAX_RADIUS] & col_mask;
                if (row_k_reg == dig_pkg::ROWK_W'(dig_pkg::DISK_N - 1)) begin
                    state_next = dig_pkg::B_DRAIN;
                end else begin
                    row_k_next = row_k_reg + dig_pkg::ROWK_W'(1);
                end
            end
            dig_pkg::B_DRAIN: begin
                state_next = dig_pkg::B_IDLE;
            end
            dig_pkg::B_QUERY: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_bit    = rd_row_valid_reg && rd_data_reg[cmd_reg.x];
                    state_next = dig_pkg::B_IDLE;
                end
            end
            default: begin
                state_next = dig_pkg::B_IDLE;
            end
        endcase
        out_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
        out_bit_next   = out_load ? out_bit : out_bit_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dig_pkg::B_IDLE;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            row_valid_reg <= '0;
        end else begin
            state_reg     <= state_next;
            wr_pend_reg   <= wr_pend_next;
            out_valid_reg <= out_valid_next;
            if (clear_grid) begin
                row_valid_reg <= '0;
            end else if (wr_pend_reg) begin
                row_valid_reg[wr_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        row_k_reg   <= row_k_next;
        wr_addr_reg <= wr_addr_next;
        mask_reg    <= mask_next;
        out_bit_reg <= out_bit_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_pend_reg) begin
            grid_mem[wr_addr_reg] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg      <= grid_mem[rd_addr];
            rd_row_valid_reg <= row_valid_reg[rd_addr];
        end
    end

    `DIG_ASSERT_NOW(a_no_stray_write, state_reg == dig_pkg::B_IDLE || state_reg == dig_pkg::B_QUERY, !wr_pend_reg, "grid write pending outside a load")
    `DIG_ASSERT_NEXT(a_drain_ends_load, state_reg == dig_pkg::B_DRAIN, state_reg == dig_pkg::B_IDLE && !wr_pend_reg, "load did not finish after drain")
    `DIG_ASSERT_NOW(a_pop_from_idle, cmd_pop, cmd_valid && state_reg == dig_pkg::B_IDLE, "command taken while busy or queue empty")
    `DIG_ASSERT_NEXT(a_query_answers, state_reg == dig_pkg::B_QUERY && out_free, m_valid, "query result not presented")

endmodule

`default_nettype wire
